### sv/chas_pkg.sv
// ----------------------------------------------------------------------------
// chas_pkg: shared definitions for the chained hash address set
// Table sizes, index widths, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package chas_pkg;

  // table geometry (bucket and pool sizes are powers of two)
  localparam int BUCKET_COUNT = 4096;
  localparam int KEY_SHIFT    = 7;
  localparam int POOL_NODES   = 4096;

  localparam int ADDR_W   = 64;
  localparam int BUCKET_W = $clog2(BUCKET_COUNT);
  localparam int NODE_W   = $clog2(POOL_NODES);
  localparam int LINK_W   = NODE_W + 1;              // {valid, node index}
  localparam int HELD_W   = $clog2(POOL_NODES + 1);
  localparam int OCC_W    = 13;
  localparam int STATUS_W = 3;
  localparam int ODATA_W  = 16;

  // reset sweep covers both the bucket and the link memory
  localparam int CLEAR_LEN = (POOL_NODES > BUCKET_COUNT) ? POOL_NODES : BUCKET_COUNT;
  localparam int CLEAR_W   = $clog2(CLEAR_LEN);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED    = 3'd0,
    ST_PRESENT     = 3'd1,
    ST_REMOVED     = 3'd2,
    ST_NOT_PRESENT = 3'd3,
    ST_POOL_FULL   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_WALK,
    S_DECIDE,
    S_ALLOC,
    S_UNLINK,
    S_RELEASE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               active;
    logic [CLEAR_W-1:0] idx;
  } sweep_t;

  // bucket = (address >> KEY_SHIFT) mod BUCKET_COUNT
  function automatic logic [BUCKET_W-1:0] bucket_of(input logic [ADDR_W-1:0] a);
    return a[KEY_SHIFT +: BUCKET_W];
  endfunction

endpackage

### sv/chas_ram.sv
// ----------------------------------------------------------------------------
// chas_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module chas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/chas_sweep.sv
// ----------------------------------------------------------------------------
// chas_sweep: post-reset init counter
// Steps one table entry per cycle from zero to the last entry, then stops.
// ----------------------------------------------------------------------------
module chas_sweep (
  input  logic            clk,
  input  logic            rst,
  output chas_pkg::sweep_t sweep
);

  logic                         active;
  logic [chas_pkg::CLEAR_W-1:0] idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b1;
      idx    <= '0;
    end else if (active) begin
      if (idx == chas_pkg::CLEAR_W'(chas_pkg::CLEAR_LEN - 1)) begin
        active <= 1'b0;
      end
      idx <= idx + 1'b1;
    end
  end

  assign sweep.active = active;
  assign sweep.idx    = idx;

endmodule

### sv/chained_hash_address_set_core.sv
// ----------------------------------------------------------------------------
// chained_hash_address_set_core: hash set of 64-bit addresses
// Separate chaining over a bounded node pool, one chain node per cycle.
// ----------------------------------------------------------------------------
// Keeps a set of 64-bit addresses. Bucket = (address >> 7) mod 4096; each
// bucket heads a linked chain of nodes taken from a 4096-node free list. An
// insert (tuser 0) walks the chain and either reports "already present",
// "pool full", or links a new node at the chain head. A remove (tuser 1)
// unlinks the matching node and returns it to the free list, or reports "not
// present". Every input beat gives exactly one result beat carrying the status
// and the count of held addresses after the operation. After reset the block
// runs an init pass over the bucket and link memories and accepts no
// beat until it ends. An accepted beat reads its bucket head, walks the
// chain and decides; a new insert then allocates a node, and a remove that
// hits unlinks the node and then releases it. Each operation ends by loading
// the result into the output register once it is free, and the sequencer
// returns to idle. The walk reads one node per cycle through the single
// read port of the key and link memories and one 64-bit key compare, and
// input is taken only while the sequencer is idle. A finished result sits
// in the output register, so the next beat can be accepted while it waits.
// ----------------------------------------------------------------------------
module chained_hash_address_set_core (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] address
  input  logic [0:0]  s_tuser,   // [0] op (0 insert, 1 remove)
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [12:0] occupancy, [15:13] zero
  output logic [2:0]  m_tuser    // [2:0] status
);

  localparam int NW = chas_pkg::NODE_W;
  localparam int BW = chas_pkg::BUCKET_W;
  localparam int LW = chas_pkg::LINK_W;

  chas_pkg::state_t  state, state_next;
  chas_pkg::sweep_t  sweep;

  // operation context
  logic                          op;
  logic [chas_pkg::ADDR_W-1:0]   addr;
  logic [BW-1:0]                 bkt;
  logic                          bvalid;
  logic [NW-1:0]                 bhead;
  logic [NW-1:0]                 cur;
  logic [NW-1:0]                 prev;
  logic                          have_prev;
  logic [NW-1:0]                 steps;
  logic                          found;
  logic [LW-1:0]                 cur_link;
  chas_pkg::status_t             status;

  // allocator state
  logic [NW-1:0]                 free_head;
  logic [chas_pkg::HELD_W-1:0]   held;

  // memory ports
  logic                          bkt_we;
  logic [BW-1:0]                 bkt_waddr;
  logic [LW-1:0]                 bkt_wdata;
  logic [BW-1:0]                 bkt_raddr;
  logic [LW-1:0]                 bkt_rdata;
  logic                          key_we;
  logic [chas_pkg::ADDR_W-1:0]   key_rdata;
  logic                          lnk_we;
  logic [NW-1:0]                 lnk_waddr;
  logic [LW-1:0]                 lnk_wdata;
  logic [LW-1:0]                 lnk_rdata;
  logic [NW-1:0]                 node_raddr;

  logic                          key_match;
  logic                          pool_full;
  logic                          walk_end;
  logic                          out_free;

  chas_sweep u_sweep (
    .clk   (clk),
    .rst   (rst),
    .sweep (sweep)
  );

  // {valid, head} per bucket
  chas_ram #(.WIDTH(LW), .DEPTH(chas_pkg::BUCKET_COUNT)) u_bucket_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .raddr (bkt_raddr),
    .rdata (bkt_rdata)
  );

  // stored address per node
  chas_ram #(.WIDTH(chas_pkg::ADDR_W), .DEPTH(chas_pkg::POOL_NODES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (free_head),
    .wdata (addr),
    .raddr (node_raddr),
    .rdata (key_rdata)
  );

  // {valid, next} per node; doubles as the free list
  chas_ram #(.WIDTH(LW), .DEPTH(chas_pkg::POOL_NODES)) u_link_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (node_raddr),
    .rdata (lnk_rdata)
  );

  // the shared compare unit: one key per cycle during the walk
  assign key_match = (key_rdata == addr);
  assign pool_full = (held >= chas_pkg::HELD_W'(chas_pkg::POOL_NODES));
  assign walk_end  = !lnk_rdata[NW] || (steps == NW'(chas_pkg::POOL_NODES - 1));
  assign out_free  = !m_tvalid || m_tready;

  assign s_tready  = (state == chas_pkg::S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      chas_pkg::S_CLEAR: begin
        if (!sweep.active) state_next = chas_pkg::S_IDLE;
      end
      chas_pkg::S_IDLE: begin
        if (s_tvalid) state_next = chas_pkg::S_HEAD;
      end
      chas_pkg::S_HEAD: begin
        state_next = bkt_rdata[NW] ? chas_pkg::S_WALK : chas_pkg::S_DECIDE;
      end
      chas_pkg::S_WALK: begin
        if (key_match || walk_end) state_next = chas_pkg::S_DECIDE;
      end
      chas_pkg::S_DECIDE: begin
        if (op == chas_pkg::OP_INSERT) begin
          state_next = (found || pool_full) ? chas_pkg::S_DONE : chas_pkg::S_ALLOC;
        end else begin
          state_next = found ? chas_pkg::S_UNLINK : chas_pkg::S_DONE;
        end
      end
      chas_pkg::S_ALLOC:   state_next = chas_pkg::S_DONE;
      chas_pkg::S_UNLINK:  state_next = chas_pkg::S_RELEASE;
      chas_pkg::S_RELEASE: state_next = chas_pkg::S_DONE;
      chas_pkg::S_DONE: begin
        if (out_free) state_next = chas_pkg::S_IDLE;
      end
      default: state_next = chas_pkg::S_CLEAR;
    endcase
  end

  // memory controls
  always_comb begin
    bkt_we     = 1'b0;
    bkt_waddr  = bkt;
    bkt_wdata  = cur_link;
    bkt_raddr  = chas_pkg::bucket_of(s_tdata);
    key_we     = 1'b0;
    lnk_we     = 1'b0;
    lnk_waddr  = cur;
    lnk_wdata  = cur_link;
    node_raddr = cur;
    unique case (state)
      chas_pkg::S_CLEAR: begin
        // empty buckets; node i links to i+1 to form the free list
        bkt_we    = sweep.active && (int'(sweep.idx) < chas_pkg::BUCKET_COUNT);
        bkt_waddr = sweep.idx[BW-1:0];
        bkt_wdata = '0;
        lnk_we    = sweep.active && (int'(sweep.idx) < chas_pkg::POOL_NODES);
        lnk_waddr = sweep.idx[NW-1:0];
        lnk_wdata = {1'b0, sweep.idx[NW-1:0] + 1'b1};
      end
      chas_pkg::S_HEAD: begin
        node_raddr = bkt_rdata[NW-1:0];
      end
      chas_pkg::S_WALK: begin
        node_raddr = lnk_rdata[NW-1:0];
      end
      chas_pkg::S_DECIDE: begin
        node_raddr = free_head;    // successor on the free list
      end
      chas_pkg::S_ALLOC: begin
        key_we    = 1'b1;
        lnk_we    = 1'b1;
        lnk_waddr = free_head;
        lnk_wdata = {bvalid, bhead};
        bkt_we    = 1'b1;
        bkt_wdata = {1'b1, free_head};
      end
      chas_pkg::S_UNLINK: begin
        // bypass the hit node: from its predecessor or from the bucket head
        lnk_we    = have_prev;
        lnk_waddr = prev;
        bkt_we    = !have_prev;
      end
      chas_pkg::S_RELEASE: begin
        lnk_we    = 1'b1;
        lnk_wdata = {1'b0, free_head};
      end
      default: begin
      end
    endcase
  end

  // sequencer state and allocator
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= chas_pkg::S_CLEAR;
      free_head <= '0;
      held      <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == chas_pkg::S_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        chas_pkg::S_ALLOC: begin
          free_head <= lnk_rdata[NW-1:0];
          held      <= held + 1'b1;
        end
        chas_pkg::S_RELEASE: begin
          free_head <= cur;
          if (held != '0) held <= held - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // operation context and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      chas_pkg::S_IDLE: begin
        op   <= s_tuser[0];
        addr <= s_tdata;
        bkt  <= chas_pkg::bucket_of(s_tdata);
      end
      chas_pkg::S_HEAD: begin
        bvalid    <= bkt_rdata[NW];
        bhead     <= bkt_rdata[NW-1:0];
        cur       <= bkt_rdata[NW-1:0];
        have_prev <= 1'b0;
        steps     <= '0;
        found     <= 1'b0;
      end
      chas_pkg::S_WALK: begin
        if (key_match) begin
          found    <= 1'b1;
          cur_link <= lnk_rdata;
        end else begin
          prev      <= cur;
          have_prev <= 1'b1;
          cur       <= lnk_rdata[NW-1:0];
          steps     <= steps + 1'b1;
        end
      end
      chas_pkg::S_DECIDE: begin
        if (op == chas_pkg::OP_INSERT) begin
          status <= found ? chas_pkg::ST_PRESENT : chas_pkg::ST_POOL_FULL;
        end else begin
          status <= chas_pkg::ST_NOT_PRESENT;
        end
      end
      chas_pkg::S_ALLOC:   status <= chas_pkg::ST_INSERTED;
      chas_pkg::S_RELEASE: status <= chas_pkg::ST_REMOVED;
      chas_pkg::S_DONE: begin
        if (out_free) begin
          m_tuser <= status;
          m_tdata <= {(chas_pkg::ODATA_W - chas_pkg::OCC_W)'(0), held[chas_pkg::OCC_W-1:0]};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### sv/chas_checker.sv
// ----------------------------------------------------------------------------
// chas_checker: port-level checks for the hash address set
// Watches both streams of the top level; attached by bind.
// ----------------------------------------------------------------------------
module chas_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [63:0] s_tdata,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // one operation at a time: no accept right after an accept
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an operation is in flight");

  // status code and occupancy stay in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= 3'(chas_pkg::ST_POOL_FULL)) &&
                 (m_tdata <= 16'(chas_pkg::POOL_NODES)))
    else $error("result out of range");

  // a fresh insert leaves at least one address held
  a_ins_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == 3'(chas_pkg::ST_INSERTED)) |-> (m_tdata != 16'd0))
    else $error("insert reported with zero occupancy");

  // a full-pool report only comes with a full pool
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == 3'(chas_pkg::ST_POOL_FULL)) |->
      (m_tdata == 16'(chas_pkg::POOL_NODES)))
    else $error("pool full reported below capacity");

endmodule

bind chained_hash_address_set_core chas_checker u_chas_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
